### src/khm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_pkg
// Shared types, constants, microcode table and round function for the
// SipHash-2-4 MAC block.
// ----------------------------------------------------------------------------
package khm_pkg;

  localparam logic [63:0] SIP_C0  = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1  = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2  = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3  = 64'h7465646279746573;
  localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_B1   = 3'd1;
  localparam step_t ST_B2   = 3'd2;
  localparam step_t ST_F1   = 3'd3;
  localparam step_t ST_F2   = 3'd4;
  localparam step_t ST_F3   = 3'd5;
  localparam step_t ST_F4   = 3'd6;
  localparam step_t ST_EMIT = 3'd7;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_WAIT_IN,
    BR_BLOCK,
    BR_WAIT_OUT
  } branch_t;

  typedef struct packed {
    logic    round;
    logic    xor_in;
    logic    xor_out;
    logic    xor_fin;
    branch_t branch;
    step_t   target;
  } ucode_t;

  // datapath control, one set per cycle
  typedef struct packed {
    logic accept;
    logic round;
    logic xor_in;
    logic xor_out;
    logic xor_fin;
    logic set_tail;
    logic emit;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic last;
    logic tail;
  } status_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sip_state_t;

  function automatic ucode_t ucode(input step_t step);
    ucode_t uc;
    uc = '{round: 1'b0, xor_in: 1'b0, xor_out: 1'b0, xor_fin: 1'b0,
           branch: BR_NEXT, target: ST_IDLE};
    case (step)
      ST_IDLE: uc.branch = BR_WAIT_IN;
      ST_B1: begin
        uc.round  = 1'b1;
        uc.xor_in = 1'b1;
      end
      ST_B2: begin
        uc.round   = 1'b1;
        uc.xor_out = 1'b1;
        uc.branch  = BR_BLOCK;
      end
      ST_F1: begin
        uc.round   = 1'b1;
        uc.xor_fin = 1'b1;
      end
      ST_F2, ST_F3, ST_F4: uc.round = 1'b1;
      ST_EMIT: uc.branch = BR_WAIT_OUT;
      default: uc.branch = BR_NEXT;
    endcase
    return uc;
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t t;
    t = s;
    t.a = t.a + t.b; t.b = rotl(t.b, 13); t.b = t.b ^ t.a; t.a = rotl(t.a, 32);
    t.c = t.c + t.d; t.d = rotl(t.d, 16); t.d = t.d ^ t.c;
    t.a = t.a + t.d; t.d = rotl(t.d, 21); t.d = t.d ^ t.a;
    t.c = t.c + t.b; t.b = rotl(t.b, 17); t.b = t.b ^ t.c; t.c = rotl(t.c, 32);
    return t;
  endfunction

endpackage

### src/khm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_seq
// Microcode sequencer: step counter, control ROM lookup and branch resolution.
// ----------------------------------------------------------------------------
module khm_seq import khm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl,
  output logic    idle
);

  step_t  step;
  step_t  step_next;
  ucode_t uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    uc            = ucode(step);
    step_next     = step;
    ctrl          = '0;
    ctrl.round    = uc.round;
    ctrl.xor_in   = uc.xor_in;
    ctrl.xor_out  = uc.xor_out;
    ctrl.xor_fin  = uc.xor_fin;
    case (uc.branch)
      BR_NEXT: step_next = step + step_t'(1);
      BR_WAIT_IN: begin
        if (status.in_valid) begin
          ctrl.accept = 1'b1;
          step_next   = step + step_t'(1);
        end
      end
      BR_BLOCK: begin
        // non-last word done; a full last word still owes its tail block
        if (!status.last) begin
          step_next = uc.target;
        end else if (!status.tail) begin
          ctrl.set_tail = 1'b1;
          step_next     = ST_B1;
        end else begin
          step_next = step + step_t'(1);
        end
      end
      BR_WAIT_OUT: begin
        if (!status.out_busy) begin
          ctrl.emit = 1'b1;
          step_next = uc.target;
        end
      end
      default: step_next = ST_IDLE;
    endcase
  end

  assign idle = (step == ST_IDLE);

endmodule

### src/khm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_core
// Datapath: key registers, v0..v3 state, one SipRound per cycle, message
// length, block formation and the output register.
// ----------------------------------------------------------------------------
module khm_core import khm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  output status_t              status,
  input  logic                 in_valid,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [63:0]          word_data,
  input  logic [3:0]           byte_count,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          hash_value
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  sip_state_t  v;
  sip_state_t  v_pre;
  sip_state_t  v_post;
  logic [63:0] word;
  logic [2:0]  tail_cnt;
  logic        last_word;
  logic        tail;
  logic        open;
  logic [7:0]  length_mod;
  logic [7:0]  len_add;
  logic        full_last;
  logic [63:0] tail_bytes;
  logic [63:0] msg;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full_last = (byte_count >= 4'd8);
  assign len_add   = !last ? 8'd8 : (full_last ? 8'd8 : {4'd0, byte_count});

  always_comb begin
    tail_bytes = '0;
    for (int i = 0; i < 7; i++) begin
      if (3'(i) < tail_cnt) tail_bytes[i*8 +: 8] = word[i*8 +: 8];
    end
  end

  assign msg = tail ? (tail_bytes | {length_mod, 56'd0}) : word;

  always_comb begin
    v_pre = v;
    if (ctrl.xor_in)  v_pre.d = v_pre.d ^ msg;
    if (ctrl.xor_fin) v_pre.c = v_pre.c ^ SIP_FIN;
    v_post = sip_round(v_pre);
    if (ctrl.xor_out) v_post.a = v_post.a ^ msg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v          <= '0;
      length_mod <= '0;
      open       <= 1'b0;
      tail       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        open <= 1'b1;
        // short last word goes straight to the tail block
        tail <= last && !full_last;
        if (!open) begin
          v.a        <= SIP_C0 ^ key_low;
          v.b        <= SIP_C1 ^ key_high;
          v.c        <= SIP_C2 ^ key_low;
          v.d        <= SIP_C3 ^ key_high;
          length_mod <= len_add;
        end else begin
          length_mod <= length_mod + len_add;
        end
      end else if (ctrl.round) begin
        v <= v_post;
      end
      if (ctrl.set_tail) tail <= 1'b1;
      if (ctrl.emit) begin
        out_valid <= 1'b1;
        open      <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      word      <= word_data;
      last_word <= last;
      tail_cnt  <= (last && !full_last) ? byte_count[2:0] : 3'd0;
    end
    if (ctrl.emit) hash_value <= v.a ^ v.b ^ v.c ^ v.d;
  end

  assign status.in_valid = in_valid;
  assign status.out_busy = out_valid && !out_ready;
  assign status.last     = last_word;
  assign status.tail     = tail;

endmodule

### src/keyed_hash_64bit_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_hash_64bit_mac
// SipHash-2-4 MAC over a stream of 64-bit little-endian message words.
// ----------------------------------------------------------------------------
// Use: write k0 (index 0) and k1 (index 1) on the cfg channel, then send the
// message one word per beat on the input channel, last marking the final
// beat with 0..8 valid bytes in byte_count (values above 8 count as 8).
// One hash beat comes out per message on the output channel.
// Timing: a microcoded sequencer runs one SipRound per cycle through a
// single round unit. A non-last word takes an accept step and two rounds
// (B1, B2). A last word then runs finalization rounds F1..F4 and the emit
// step, after an extra block when it holds 8 bytes. The hash is valid
// the cycle after emit. The new key is picked up at the next message start.
// Reset clears the key, the state and the output valid flag; no clearing
// pass is needed. The output register holds a finished hash while further
// words are absorbed; only a second hash waits, at its emit step, for the
// receiver to take the first.
// ----------------------------------------------------------------------------
module keyed_hash_64bit_mac import khm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          word_data,
  input  logic [3:0]           byte_count,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          hash_value
);

  ctrl_t   ctrl;
  status_t status;
  logic    idle;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;

  khm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  khm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .in_valid   (in_valid),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .word_data  (word_data),
    .byte_count (byte_count),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule

### sim/tb_keyed_hash_64bit_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_hash_64bit_mac
// Self-checking regression for the SipHash-2-4 MAC block. Key writes and
// message words are driven on their valid/ready channels from queues. A
// behavioural SipHash model, updated on every accepted word, predicts each
// hash, and the monitor compares it with every hash beat the block emits.
// Directed messages cover the byte count extremes, saturation, masking, empty
// and single-word messages, key extremes and a key change mid-message. Random
// messages follow, with random back-pressure and idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_keyed_hash_64bit_mac import khm_pkg::*;;

  localparam int unsigned CLK_HALF    = 6;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned END_WAIT    = 20;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_WORDS = 150;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        lst;
  } word_beat_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          val;
  } key_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [63:0]          word_data = '0;
  logic [3:0]           byte_count = '0;
  logic                 last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [63:0]          hash_value;

  keyed_hash_64bit_mac DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word_data  (word_data),
    .byte_count (byte_count),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  word_beat_t  word_q[$];
  key_beat_t   key_q[$];
  logic [63:0] hash_expected[$];

  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  logic        gaps_on = 1'b1;

  // model state
  logic [63:0] key_lo = '0;
  logic [63:0] key_hi = '0;
  lanes_t      lanes = '0;
  logic [7:0]  len_mod = '0;
  logic        msg_open = 1'b0;

  logic [63:0] want;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned hashes_checked = 0;
  int unsigned words_taken = 0;
  int unsigned msgs_sent = 0;
  int unsigned key_writes = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // SipHash model
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rol(input logic [63:0] x, input int unsigned r);
    logic [127:0] dbl;
    dbl = {x, x} << r;
    return dbl[127:64];
  endfunction

  function automatic lanes_t mix_round(input lanes_t s);
    lanes_t r;
    r = s;
    r.a = r.a + r.b; r.b = rol(r.b, 13) ^ r.a; r.a = rol(r.a, 32);
    r.c = r.c + r.d; r.d = rol(r.d, 16) ^ r.c;
    r.a = r.a + r.d; r.d = rol(r.d, 21) ^ r.a;
    r.c = r.c + r.b; r.b = rol(r.b, 17) ^ r.c; r.c = rol(r.c, 32);
    return r;
  endfunction

  function automatic lanes_t absorb_block(input lanes_t s, input logic [63:0] m);
    lanes_t r;
    r = s;
    r.d = r.d ^ m;
    r = mix_round(mix_round(r));
    r.a = r.a ^ m;
    return r;
  endfunction

  task automatic take_word(input logic [63:0] w, input logic [3:0] bc, input logic lst);
    logic [3:0]  n;
    logic [63:0] blk;
    if (!msg_open) begin
      lanes.a  = SIP_C0 ^ key_lo;
      lanes.b  = SIP_C1 ^ key_hi;
      lanes.c  = SIP_C2 ^ key_lo;
      lanes.d  = SIP_C3 ^ key_hi;
      len_mod  = '0;
      msg_open = 1'b1;
    end
    if (!lst) begin
      lanes   = absorb_block(lanes, w);
      len_mod = len_mod + 8'd8;
    end else begin
      n = (bc > 4'd8) ? 4'd8 : bc;
      if (n == 4'd8) begin
        lanes   = absorb_block(lanes, w);
        len_mod = len_mod + 8'd8;
        blk     = '0;
      end else begin
        blk     = w & ~(ALL_ONES << {n, 3'b000});
        len_mod = len_mod + {4'd0, n};
      end
      lanes   = absorb_block(lanes, blk | {len_mod, 56'd0});
      lanes.c = lanes.c ^ SIP_FIN;
      lanes   = mix_round(mix_round(mix_round(mix_round(lanes))));
      hash_expected.push_back(lanes.a ^ lanes.b ^ lanes.c ^ lanes.d);
      msg_open = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // drivers: everything changes on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    word_beat_t wb;
    if (!in_valid || in_fire) begin
      if (word_q.size() != 0 && !(gaps_on && $urandom_range(99) < 8)) begin
        wb = word_q.pop_front();
        word_data  <= wb.word;
        byte_count <= wb.cnt;
        last       <= wb.lst;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    key_beat_t kb;
    if (!cfg_valid || cfg_fire) begin
      if (key_q.size() != 0) begin
        kb = key_q.pop_front();
        cfg_index <= kb.idx;
        cfg_data  <= kb.val;
        cfg_valid <= 1'b1;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !(gaps_on && $urandom_range(99) < 8);
  end

  // --------------------------------------------------------------------------
  // monitor, scoreboard and watchdog
  // --------------------------------------------------------------------------
  task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_fire      <= 1'b0;
      cfg_fire     <= 1'b0;
      stall_cycles = 0;
    end else begin
      in_fire  <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        key_writes++;
        if (cfg_index == REG_KEY_LOW)
          key_lo = cfg_data;
        else if (cfg_index == REG_KEY_HIGH)
          key_hi = cfg_data;
      end
      if (in_valid && in_ready) begin
        words_taken++;
        take_word(word_data, byte_count, last);
      end
      if (out_valid && out_ready) begin
        if (hash_expected.size() == 0) begin
          report("hash beat with none pending", '0, hash_value);
        end else begin
          want = hash_expected.pop_front();
          hashes_checked++;
          if (hash_value !== want)
            report("hash_value mismatch", want, hash_value);
        end
      end
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
        $display("keyed_hash_64bit_mac regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic push_word(input logic [63:0] w, input logic [3:0] c, input logic l);
    word_beat_t wb;
    wb.word = w;
    wb.cnt  = c;
    wb.lst  = l;
    word_q.push_back(wb);
    if (l)
      msgs_sent++;
  endtask

  function automatic logic [63:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5)
      return '0;
    else if (pick < 10)
      return ALL_ONES;
    else
      return {$urandom, $urandom};
  endfunction

  // non-last words carry junk byte counts on purpose
  task automatic push_body(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_word(rand_word(), 4'($urandom_range(15)), 1'b0);
  endtask

  task automatic push_msg(input int unsigned n_body);
    logic [3:0] c;
    c = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
    push_body(n_body);
    push_word(rand_word(), c, 1'b1);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    key_beat_t kb;
    kb.idx = idx;
    kb.val = val;
    key_q.push_back(kb);
    while (key_q.size() != 0 || cfg_valid) @(posedge clk);
  endtask

  // wait for every word to go in and every hash to come out, then let the
  // datapath finish any body word still in flight
  task automatic drain(input int unsigned extra);
    while (word_q.size() != 0 || in_valid || hash_expected.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0)
      return '0;
    else if (pick == 1)
      return ALL_ONES;
    else
      return {$urandom, $urandom};
  endfunction

  initial begin
    int unsigned budget;
    int unsigned n_body;
    int unsigned pick;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // reset key: empty message
    push_word(rand_word(), 4'd0, 1'b1);
    drain(DRAIN_WAIT);

    write_key(REG_KEY_LOW,  64'h0706050403020100);
    write_key(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    write_key(REG_SPARE_2,  ALL_ONES);
    write_key(REG_SPARE_3,  ALL_ONES);

    // masking of tail bytes, byte count extremes and saturation
    push_word(ALL_ONES, 4'd0, 1'b1);
    push_word(ALL_ONES, 4'd1, 1'b1);
    push_word(ALL_ONES, 4'd3, 1'b1);
    push_word(ALL_ONES, 4'd7, 1'b1);
    push_word(ALL_ONES, 4'd8, 1'b1);
    push_word({$urandom, $urandom}, 4'd9, 1'b1);
    push_word({$urandom, $urandom}, 4'd15, 1'b1);
    // body words with junk counts
    push_word('0, 4'd15, 1'b0);
    push_word(ALL_ONES, 4'd5, 1'b1);
    push_word(64'h0706050403020100, 4'd0, 1'b0);
    push_word(ALL_ONES, 4'd8, 1'b0);
    push_word(64'h0f0e0d0c0b0a0908, 4'd8, 1'b1);
    drain(DRAIN_WAIT);

    write_key(REG_KEY_LOW,  ALL_ONES);
    write_key(REG_KEY_HIGH, ALL_ONES);
    push_word('0, 4'd0, 1'b1);
    push_word(ALL_ONES, 4'd8, 1'b1);

    // key change with a message open: the old key stays in force
    push_word({$urandom, $urandom}, 4'd0, 1'b0);
    push_word({$urandom, $urandom}, 4'd3, 1'b0);
    drain(DRAIN_WAIT);
    write_key(REG_KEY_LOW,  '0);
    write_key(REG_KEY_HIGH, {$urandom, $urandom});
    push_word({$urandom, $urandom}, 4'd6, 1'b1);
    push_word({$urandom, $urandom}, 4'd2, 1'b1);
    drain(DRAIN_WAIT);

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      // phase 2 runs flat out on both sides
      gaps_on = (ph != 2);
      pick = $urandom_range(2);
      if (pick != 1)
        write_key(REG_KEY_LOW, rand_key());
      if (pick != 0)
        write_key(REG_KEY_HIGH, rand_key());
      budget = 0;
      while (budget < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 5)
          n_body = $urandom_range(40, 33);   // length wraps past 255 bytes
        else if (pick < 60)
          n_body = 0;
        else
          n_body = $urandom_range(5, 1);
        push_msg(n_body);
        budget += n_body + 1;
      end
      // leave a message open across the next key change
      if (ph == 1 || ph == 3)
        push_body($urandom_range(3, 1));
      drain(DRAIN_WAIT);
    end

    drain(END_WAIT);
    $display("Ran %0d messages over %0d words with %0d key writes, random stalls both sides.",
             msgs_sent, words_taken, key_writes);
    $display("Checked %0d hashes, %0d mismatches.", hashes_checked, mismatches);
    if (mismatches == 0 && hash_expected.size() == 0) begin
      $display("keyed_hash_64bit_mac regression: pass");
    end else begin
      $display("keyed_hash_64bit_mac regression: fail");
    end
    $finish;
  end

endmodule
